// ----- rtl/cwm_pkg.sv -----
package cwm_pkg;

    // sizing
    localparam int MAX_FRAME   = 4096;
    localparam int PHASE_BITS  = 10;
    localparam int SAMPLE_BITS = 16;

    localparam int TABLE_SIZE  = 1 << PHASE_BITS;
    localparam int QTR_BITS    = PHASE_BITS - 2;
    localparam int QTR_SIZE    = 1 << QTR_BITS;

    // stream words are whole bytes
    localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

    // frame length register and derived widths
    localparam int LEN_W       = 13;
    localparam int RESET_FRAME = 1024;
    localparam int DEN_W       = $clog2(MAX_FRAME);
    localparam int NR_W        = $clog2(MAX_FRAME - 1 + TABLE_SIZE);
    localparam int DIV_CNT_W   = $clog2(NR_W);

    // configuration port
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = LEN_W;

    // arithmetic widths
    localparam int COS_W       = 16;
    localparam int COEF_W      = 17;
    localparam int ACC_W       = 34;
    localparam int WGT_W       = 16;
    localparam int WGT_ONE     = 32768;
    localparam int PROD_W      = SAMPLE_BITS + WGT_W + 2;
    localparam int RES_W       = PROD_W - 15;

    // queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] HALF_PI_Q62 = 64'h6487ED5110B4611A;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_WINDOW_TYPE  = 1'b0,
        REG_FRAME_LENGTH = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        WIN_HAMMING   = 2'd0,
        WIN_HANN      = 2'd1,
        WIN_BLACKMAN  = 2'd2,
        WIN_BLACKHARR = 2'd3
    } win_t;

    // cosine terms of the window sum
    typedef enum logic [1:0] {
        TERM_1 = 2'd0,
        TERM_2 = 2'd1,
        TERM_3 = 2'd2
    } term_t;

    typedef enum logic {
        FE_IDLE,
        FE_DIV
    } fe_state_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_LOOK,
        BK_MAC,
        BK_WGT,
        BK_MUL,
        BK_OUT
    } bk_state_t;

    // one classified sample on its way to the back end
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic [PHASE_BITS-1:0]         phase3;
        logic [PHASE_BITS-1:0]         phase2;
        logic [PHASE_BITS-1:0]         phase1;
        win_t                          wtype;
        logic                          last;
    } item_t;

    typedef logic [QTR_SIZE-1:0][COS_W-1:0] qtab_t;

    // 64x64 unsigned product, Q62 result
    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] al, ah, bl, bh, ll, lh, hl, hh, mid, lo, hi;
        al  = {32'd0, a[31:0]};
        ah  = {32'd0, a[63:32]};
        bl  = {32'd0, b[31:0]};
        bh  = {32'd0, b[63:32]};
        ll  = al * bl;
        lh  = al * bh;
        hl  = ah * bl;
        hh  = ah * bh;
        mid = (ll >> 32) + {32'd0, lh[31:0]} + {32'd0, hl[31:0]};
        lo  = {mid[31:0], ll[31:0]};
        hi  = hh + (lh >> 32) + (hl >> 32) + (mid >> 32);
        return {hi[61:0], lo[63:62]};
    endfunction

    // taylor series for sine or cosine in Q62, argument in the first quadrant
    function automatic logic signed [63:0] taylor_q62(input logic [63:0] x,
                                                      input logic want_sin);
        logic [63:0]        term;
        logic signed [63:0] cs;
        logic signed [63:0] sn;
        term = 64'd1 << 62;
        cs   = '0;
        sn   = '0;
        for (int n = 0; n < 32; n++) begin
            unique case (n[1:0])
                2'd0: cs = cs + $signed(term);
                2'd1: sn = sn + $signed(term);
                2'd2: cs = cs - $signed(term);
                default: sn = sn - $signed(term);
            endcase
            term = mul_q62(term, x) / 64'(n + 1);
        end
        return want_sin ? sn : cs;
    endfunction

    // scale to 32767 and round half away from zero
    function automatic logic [COS_W-1:0] round_entry(input logic signed [63:0] v);
        logic        neg;
        logic [63:0] m;
        logic [63:0] e;
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        e   = ((m >> 20) * 64'd32767 + (64'd1 << 41)) >> 42;
        return neg ? COS_W'(-e) : COS_W'(e);
    endfunction

    // quarter wave table, evaluated at elaboration
    function automatic qtab_t build_quarter(input logic want_sin);
        qtab_t       tab;
        logic [63:0] step;
        step = HALF_PI_Q62 >> QTR_BITS;
        for (int j = 0; j < QTR_SIZE; j++) begin
            tab[j] = round_entry(taylor_q62(step * 64'(j), want_sin));
        end
        return tab;
    endfunction

    localparam qtab_t COS_QTR = build_quarter(1'b0);
    localparam qtab_t SIN_QTR = build_quarter(1'b1);

    // full period cosine from the quarter tables
    function automatic logic signed [COS_W-1:0] cos_lookup(input logic [PHASE_BITS-1:0] p);
        logic [1:0]          quad;
        logic [QTR_BITS-1:0] j;
        logic signed [COS_W-1:0] c;
        logic signed [COS_W-1:0] s;
        quad = p[PHASE_BITS-1 -: 2];
        j    = p[QTR_BITS-1:0];
        c    = $signed(COS_QTR[j]);
        s    = $signed(SIN_QTR[j]);
        unique case (quad)
            2'd0: return c;
            2'd1: return -s;
            2'd2: return -c;
            default: return s;
        endcase
    endfunction

    // constant term A in Q0.16
    function automatic logic [15:0] coef_a(input win_t t);
        unique case (t)
            WIN_HAMMING:  return 16'd35389;
            WIN_HANN:     return 16'd32768;
            WIN_BLACKMAN: return 16'd27525;
            default:      return 16'd23511;
        endcase
    endfunction

    // signed weight of each cosine term: -B, +C, -D
    function automatic logic signed [COEF_W-1:0] coef_term(input win_t t, input term_t k);
        unique case (k)
            TERM_1: begin
                unique case (t)
                    WIN_HAMMING:  return -17'sd30147;
                    WIN_HANN:     return -17'sd32768;
                    WIN_BLACKMAN: return -17'sd32768;
                    default:      return -17'sd32001;
                endcase
            end
            TERM_2: begin
                unique case (t)
                    WIN_BLACKMAN:  return 17'sd5243;
                    WIN_BLACKHARR: return 17'sd9259;
                    default:       return 17'sd0;
                endcase
            end
            TERM_3: begin
                if (t == WIN_BLACKHARR) return -17'sd765;
                return 17'sd0;
            end
            default: return 17'sd0;
        endcase
    endfunction

endpackage

// ----- rtl/cwm_front.sv -----
module cwm_front (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [cwm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [cwm_pkg::SAMPLE_BITS-1:0]   in_sample,
    input  logic                              queue_full,
    output logic                              push,
    output cwm_pkg::item_t                    push_item
);

    localparam int PB = cwm_pkg::PHASE_BITS;
    localparam int DW = cwm_pkg::DEN_W;

    cwm_pkg::fe_state_t state_reg, state_next;
    cwm_pkg::win_t      wtype_reg;
    logic [DW-1:0]      den_reg;
    logic [DW-1:0]      pos_reg;
    logic [PB-1:0]      q_reg;
    logic [DW-1:0]      r_reg;
    logic [cwm_pkg::NR_W-1:0]      num_reg;
    logic [DW-1:0]                 rem_reg;
    logic [PB-1:0]                 quo_reg;
    logic [cwm_pkg::DIV_CNT_W-1:0] cnt_reg;

    logic          accept;
    logic          last;
    logic          start_div;
    logic          div_step;
    logic          div_done;
    logic          len_write;
    logic          type_write;
    logic [cwm_pkg::LEN_W-1:0] len;
    logic [DW-1:0] den_next;
    logic [DW:0]   trial;
    logic          ge;
    logic [DW-1:0] rem_next;
    logic [DW:0]   two_r;
    logic [DW+1:0] three_r;
    logic          c2;
    logic [1:0]    c3;
    logic [PB-1:0] p2;
    logic [PB-1:0] p3;

    // configuration decode
    assign len_write  = cfg_we && (cfg_index == cwm_pkg::REG_FRAME_LENGTH);
    assign type_write = cfg_we && (cfg_index == cwm_pkg::REG_WINDOW_TYPE);
    assign len        = cfg_data[cwm_pkg::LEN_W-1:0];

    // frame length clamped into range, kept as N-1
    always_comb
    begin
        if (len < cwm_pkg::LEN_W'(2))
            den_next = DW'(1);
        else if (int'(len) > cwm_pkg::MAX_FRAME)
            den_next = DW'(cwm_pkg::MAX_FRAME - 1);
        else
            den_next = DW'(len - cwm_pkg::LEN_W'(1));
    end

    assign accept = in_valid && in_ready;
    assign last   = pos_reg >= den_reg;

    // phase indices of the three terms from quotient and remainder
    assign two_r   = {r_reg, 1'b0};
    assign three_r = (DW+2)'(r_reg) * (DW+2)'(3);
    assign c2      = two_r >= {1'b0, den_reg};
    always_comb
    begin
        if (three_r >= {1'b0, den_reg, 1'b0})
            c3 = 2'd2;
        else if (three_r >= (DW+2)'(den_reg))
            c3 = 2'd1;
        else
            c3 = 2'd0;
    end
    assign p2 = PB'({q_reg, 1'b0}) + PB'(c2);
    assign p3 = PB'((PB+2)'(q_reg) * (PB+2)'(3)) + PB'(c3);

    always_comb
    begin
        push_item.sample = $signed(in_sample);
        push_item.phase1 = q_reg;
        push_item.phase2 = p2;
        push_item.phase3 = p3;
        push_item.wtype  = wtype_reg;
        push_item.last   = last;
    end

    // one restoring divide step: (r + table size) by N-1
    assign trial    = {rem_reg, num_reg[cwm_pkg::NR_W-1]};
    assign ge       = trial >= {1'b0, den_reg};
    assign rem_next = ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwm_pkg::FE_IDLE:
            begin
                if (accept && !last)
                    state_next = cwm_pkg::FE_DIV;
            end
            cwm_pkg::FE_DIV:
            begin
                if (cnt_reg == '0)
                    state_next = cwm_pkg::FE_IDLE;
            end
            default: state_next = cwm_pkg::FE_IDLE;
        endcase
        if (len_write)
            state_next = cwm_pkg::FE_IDLE;
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready  = 1'b0;
        div_step  = 1'b0;
        div_done  = 1'b0;
        unique case (state_reg)
            cwm_pkg::FE_IDLE: in_ready = !queue_full;
            cwm_pkg::FE_DIV:
            begin
                div_step = 1'b1;
                div_done = cnt_reg == '0;
            end
            default: in_ready = 1'b0;
        endcase
        push      = accept;
        start_div = accept && !last;
    end

    // sequencer and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cwm_pkg::FE_IDLE;
            wtype_reg <= cwm_pkg::WIN_HAMMING;
            den_reg   <= DW'(cwm_pkg::RESET_FRAME - 1);
            pos_reg   <= '0;
            q_reg     <= '0;
            r_reg     <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (type_write)
                wtype_reg <= cwm_pkg::win_t'(cfg_data[1:0]);
            if (len_write)
            begin
                den_reg <= den_next;
                pos_reg <= '0;
                q_reg   <= '0;
                r_reg   <= '0;
            end
            else if (accept)
            begin
                if (last)
                begin
                    pos_reg <= '0;
                    q_reg   <= '0;
                    r_reg   <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + DW'(1);
                end
            end
            else if (div_done)
            begin
                q_reg <= q_reg + {quo_reg[PB-2:0], ge};
                r_reg <= rem_next;
            end
            if (start_div)
                cnt_reg <= cwm_pkg::DIV_CNT_W'(cwm_pkg::NR_W - 1);
            else if (div_step)
                cnt_reg <= cnt_reg - cwm_pkg::DIV_CNT_W'(1);
        end
    end

    // divider datapath
    always_ff @(posedge clk)
    begin
        if (start_div)
        begin
            num_reg <= cwm_pkg::NR_W'(r_reg) + cwm_pkg::NR_W'(cwm_pkg::TABLE_SIZE);
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (div_step)
        begin
            num_reg <= {num_reg[cwm_pkg::NR_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[PB-2:0], ge};
        end
    end

endmodule

// ----- rtl/cwm_queue.sv -----
module cwm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cwm_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output cwm_pkg::item_t pop_item,
    output logic           empty
);

    cwm_pkg::item_t                   entry_reg [cwm_pkg::QUEUE_DEPTH];
    logic [cwm_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [cwm_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [cwm_pkg::QCNT_W-1:0]       count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign full     = count_reg == cwm_pkg::QCNT_W'(cwm_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = entry_reg[rd_ptr_reg];

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == cwm_pkg::QPTR_W'(cwm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + cwm_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == cwm_pkg::QPTR_W'(cwm_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + cwm_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + cwm_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - cwm_pkg::QCNT_W'(1);
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- rtl/cwm_back.sv -----
module cwm_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    output logic                            pop,
    input  cwm_pkg::item_t                  pop_item,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [cwm_pkg::DATA_W-1:0]      out_data,
    output logic                            out_last
);

    localparam int SB    = cwm_pkg::SAMPLE_BITS;
    localparam int AW    = cwm_pkg::ACC_W;
    localparam int PW    = cwm_pkg::PROD_W;
    localparam int RW    = cwm_pkg::RES_W;
    localparam int MW    = cwm_pkg::COEF_W + cwm_pkg::COS_W;
    localparam int SMW   = SB + cwm_pkg::WGT_W + 1;
    localparam logic signed [RW-1:0] SAT_MAX = RW'((2 ** (SB - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_MIN = -RW'(2 ** (SB - 1));

    cwm_pkg::bk_state_t state_reg, state_next;
    cwm_pkg::item_t     item_reg;
    cwm_pkg::term_t     term_reg;
    logic signed [cwm_pkg::COS_W-1:0]  cos_reg;
    logic signed [cwm_pkg::COEF_W-1:0] coef_reg;
    logic signed [AW-1:0]              acc_reg;
    logic [cwm_pkg::WGT_W-1:0]         wgt_reg;
    logic signed [PW-1:0]              prod_reg;
    logic [SB-1:0]                     out_data_reg;
    logic                              out_last_reg;
    logic                              out_valid_reg;

    logic                      load_item;
    logic                      load_cos;
    logic                      do_mac;
    logic                      load_wgt;
    logic                      load_prod;
    logic                      load_out;
    logic [cwm_pkg::PHASE_BITS-1:0] phase_sel;
    logic signed [MW-1:0]      mac_prod;
    logic signed [AW-1:0]      acc_rnd;
    logic [AW-17:0]            w_full;
    logic [cwm_pkg::WGT_W-1:0] wgt_next;
    logic signed [SMW-1:0]     smp_prod;
    logic signed [RW-1:0]      res;
    logic signed [RW-1:0]      res_sat;
    cwm_pkg::term_t            term_inc;

    // phase of the term in work
    always_comb
    begin
        unique case (term_reg)
            cwm_pkg::TERM_1: phase_sel = item_reg.phase1;
            cwm_pkg::TERM_2: phase_sel = item_reg.phase2;
            cwm_pkg::TERM_3: phase_sel = item_reg.phase3;
            default:         phase_sel = item_reg.phase1;
        endcase
    end

    always_comb
    begin
        unique case (term_reg)
            cwm_pkg::TERM_1: term_inc = cwm_pkg::TERM_2;
            cwm_pkg::TERM_2: term_inc = cwm_pkg::TERM_3;
            default:         term_inc = cwm_pkg::TERM_1;
        endcase
    end

    // shared term multiplier
    assign mac_prod = coef_reg * cos_reg;

    // weight rounded to Q1.15 and clamped to 0..1
    assign acc_rnd = acc_reg + AW'(32768);
    assign w_full  = acc_rnd[AW-1:16];
    always_comb
    begin
        if (acc_reg[AW-1] || (acc_reg == '0))
            wgt_next = '0;
        else if (w_full > (AW-16)'(cwm_pkg::WGT_ONE))
            wgt_next = cwm_pkg::WGT_W'(cwm_pkg::WGT_ONE);
        else
            wgt_next = w_full[cwm_pkg::WGT_W-1:0];
    end

    // sample times weight
    assign smp_prod = item_reg.sample * $signed({1'b0, wgt_reg});

    // round down after the half bias, then saturate
    assign res = prod_reg[PW-1:15];
    always_comb
    begin
        if (res > SAT_MAX)
            res_sat = SAT_MAX;
        else if (res < SAT_MIN)
            res_sat = SAT_MIN;
        else
            res_sat = res;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cwm_pkg::BK_IDLE:
            begin
                if (!empty)
                    state_next = cwm_pkg::BK_LOOK;
            end
            cwm_pkg::BK_LOOK: state_next = cwm_pkg::BK_MAC;
            cwm_pkg::BK_MAC:
            begin
                if (term_reg == cwm_pkg::TERM_3)
                    state_next = cwm_pkg::BK_WGT;
                else
                    state_next = cwm_pkg::BK_LOOK;
            end
            cwm_pkg::BK_WGT:  state_next = cwm_pkg::BK_MUL;
            cwm_pkg::BK_MUL:  state_next = cwm_pkg::BK_OUT;
            cwm_pkg::BK_OUT:
            begin
                if (!out_valid_reg || out_ready)
                    state_next = cwm_pkg::BK_IDLE;
            end
            default: state_next = cwm_pkg::BK_IDLE;
        endcase
    end

    // sequencer strobes
    always_comb
    begin
        load_item = 1'b0;
        load_cos  = 1'b0;
        do_mac    = 1'b0;
        load_wgt  = 1'b0;
        load_prod = 1'b0;
        load_out  = 1'b0;
        unique case (state_reg)
            cwm_pkg::BK_IDLE: load_item = !empty;
            cwm_pkg::BK_LOOK: load_cos  = 1'b1;
            cwm_pkg::BK_MAC:  do_mac    = 1'b1;
            cwm_pkg::BK_WGT:  load_wgt  = 1'b1;
            cwm_pkg::BK_MUL:  load_prod = 1'b1;
            cwm_pkg::BK_OUT:  load_out  = !out_valid_reg || out_ready;
            default:          load_item = 1'b0;
        endcase
    end

    assign pop = load_item;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwm_pkg::BK_IDLE;
            term_reg      <= cwm_pkg::TERM_1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_item)
                term_reg <= cwm_pkg::TERM_1;
            else if (do_mac)
                term_reg <= term_inc;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (load_item)
        begin
            item_reg <= pop_item;
            acc_reg  <= $signed(AW'({cwm_pkg::coef_a(pop_item.wtype), 15'd0}));
        end
        else if (do_mac)
        begin
            acc_reg <= acc_reg + AW'(mac_prod);
        end
        if (load_cos)
        begin
            cos_reg  <= cwm_pkg::cos_lookup(phase_sel);
            coef_reg <= cwm_pkg::coef_term(item_reg.wtype, term_reg);
        end
        if (load_wgt)
            wgt_reg <= wgt_next;
        if (load_prod)
            prod_reg <= PW'(smp_prod) + PW'(16384);
        if (load_out)
        begin
            out_data_reg <= res_sat[SB-1:0];
            out_last_reg <= item_reg.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = cwm_pkg::DATA_W'(out_data_reg);
    assign out_last  = out_last_reg;

endmodule

// ----- rtl/cosine_window_multiplier.sv -----
// Cosine window multiplier: multiplies each signed Q1.15 sample of a frame of N samples by a
// Hamming, Hann, Blackman or Blackman-Harris weight and flags the last sample of the frame on
// tlast. A front end tracks the frame position and the window phase as quotient and remainder
// by N-1 with a bit-serial restoring divider; after a sample that is not the last of its frame
// it runs that divider and takes no new sample until the divider is done; the last sample of
// a frame starts no division, so the input stays ready while the queue has room. A two-entry
// queue passes classified samples to a back end that sums the three cosine terms through one
// shared multiplier and then scales the sample, overlapped with the front end. Writing
// frame_length restarts the frame; window_type takes effect on the next sample. Configure
// only while the block holds no pending samples.
module cosine_window_multiplier (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [cwm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cwm_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [cwm_pkg::DATA_W-1:0]       s_axis_tdata,   // sample
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [cwm_pkg::DATA_W-1:0]       m_axis_tdata,   // windowed_sample
    output logic                             m_axis_tlast    // frame_end
);

    cwm_pkg::item_t push_item;
    cwm_pkg::item_t pop_item;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // position, phase and divider
    cwm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_sample  (s_axis_tdata[cwm_pkg::SAMPLE_BITS-1:0]),
        .queue_full (queue_full),
        .push       (push),
        .push_item  (push_item)
    );

    // decoupling queue
    cwm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    // weight and product
    cwm_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .empty     (queue_empty),
        .pop       (pop),
        .pop_item  (pop_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

// ----- rtl/cwm_checker.sv -----
module cwm_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [cwm_pkg::DATA_W-1:0]  m_axis_tdata,
    input  logic                        m_axis_tlast
);

    // queue entries plus the back end item plus the output register
    localparam int CAP    = cwm_pkg::QUEUE_DEPTH + 2;
    localparam int PEND_W = $clog2(CAP + 2);

    logic [PEND_W-1:0] pend_reg;
    logic              in_acc;
    logic              out_acc;

    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;

    // samples taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (in_acc && !out_acc)
            pend_reg <= pend_reg + PEND_W'(1);
        else if (out_acc && !in_acc)
            pend_reg <= pend_reg - PEND_W'(1);
    end

    // reset empties the output register
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result shown during reset");

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // every result comes from a sample taken earlier
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pend_reg != '0)
        else $error("result without a pending sample");

    // no more samples in flight than the storage holds
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= PEND_W'(CAP))
        else $error("more samples pending than the block can hold");

endmodule

bind cosine_window_multiplier cwm_checker u_cwm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
